### src/dpo_pkg.sv
`default_nettype none

package dpo_pkg;

    // Coordinate width; radii are one bit narrower, pushes one bit wider
    localparam int CB      = 16;
    localparam int SQ_W    = 2 * CB;
    localparam int IDX_W   = $clog2(CB);
    localparam int IN_W    = 6 * CB - 2;
    localparam int IN_PAD  = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W   = 3 * CB + 3;
    localparam int OUT_PAD = ((OUT_W + 7) / 8) * 8;

    // Payload carried alongside the square root chain
    typedef struct packed {
        logic          hit;
        logic [CB-1:0] rsum;
        logic [CB-1:0] adx;
        logic [CB-1:0] ady;
        logic          sx;
        logic          sy;
    } sq_pay_t;

    // Working state of the square root: remainder and partial root
    typedef struct packed {
        logic [SQ_W-1:0] n;
        logic [SQ_W-1:0] root;
    } sq_st_t;

    // Payload carried alongside the divider chain
    typedef struct packed {
        logic          hit;
        logic [CB-1:0] depth;
        logic [CB-1:0] span;
        logic          zd;
        logic          sx;
        logic          sy;
    } dv_pay_t;

    // Divider lanes: upper half is the partial remainder, lower half
    // shifts dividend bits out and quotient bits in
    typedef struct packed {
        logic [SQ_W-1:0] wx;
        logic [SQ_W-1:0] wy;
    } dv_lane_t;

    // Trial bit of square root cell idx, counted from the top digit
    function automatic logic [SQ_W-1:0] sq_bit(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] pos;
        pos = IDX_W'(CB - 1) - idx;
        return {{(SQ_W-1){1'b0}}, 1'b1} << {pos, 1'b0};
    endfunction

endpackage

`default_nettype wire

### src/dpo_sqrt_cell.sv
`default_nettype none

module dpo_sqrt_cell (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        en,
    input  wire logic [dpo_pkg::IDX_W-1:0]   idx,
    input  wire logic                        vld_in,
    input  wire dpo_pkg::sq_pay_t            pay_in,
    input  wire dpo_pkg::sq_st_t             st_in,
    output logic                             vld_out,
    output dpo_pkg::sq_pay_t                 pay_out,
    output dpo_pkg::sq_st_t                  st_out
);
    import dpo_pkg::*;

    logic            vld_reg;
    sq_pay_t         pay_reg;
    sq_st_t          st_reg;
    sq_st_t          st_next;
    logic [SQ_W-1:0] bit_val;
    logic [SQ_W-1:0] trial;

    // Resolve one root digit
    always_comb begin
        bit_val = sq_bit(idx);
        trial   = st_in.root + bit_val;
        if (st_in.n >= trial) begin
            st_next.n    = st_in.n - trial;
            st_next.root = (st_in.root >> 1) + bit_val;
        end else begin
            st_next.n    = st_in.n;
            st_next.root = st_in.root >> 1;
        end
    end

    // Advance the chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pay_reg <= pay_in;
            st_reg  <= st_next;
        end
    end

    assign vld_out = vld_reg;
    assign pay_out = pay_reg;
    assign st_out  = st_reg;

endmodule

`default_nettype wire

### src/dpo_div_cell.sv
`default_nettype none

module dpo_div_cell (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               en,
    input  wire logic               vld_in,
    input  wire dpo_pkg::dv_pay_t   pay_in,
    input  wire dpo_pkg::dv_lane_t  lane_in,
    output logic                    vld_out,
    output dpo_pkg::dv_pay_t        pay_out,
    output dpo_pkg::dv_lane_t       lane_out
);
    import dpo_pkg::*;

    logic            vld_reg;
    dv_pay_t         pay_reg;
    dv_lane_t        lane_reg;
    dv_lane_t        lane_next;
    logic [CB:0]     tx;
    logic [CB:0]     ty;
    logic [CB:0]     dvs;
    logic            gx;
    logic            gy;
    logic [CB:0]     rx;
    logic [CB:0]     ry;

    // One restoring step per lane, shared divisor
    always_comb begin
        dvs = {1'b0, pay_in.span};
        tx  = {lane_in.wx[SQ_W-1:CB], lane_in.wx[CB-1]};
        ty  = {lane_in.wy[SQ_W-1:CB], lane_in.wy[CB-1]};
        gx  = (tx >= dvs);
        gy  = (ty >= dvs);
        rx  = gx ? tx - dvs : tx;
        ry  = gy ? ty - dvs : ty;
        lane_next.wx = {rx[CB-1:0], lane_in.wx[CB-2:0], gx};
        lane_next.wy = {ry[CB-1:0], lane_in.wy[CB-2:0], gy};
    end

    // Advance the chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pay_reg  <= pay_in;
            lane_reg <= lane_next;
        end
    end

    assign vld_out  = vld_reg;
    assign pay_out  = pay_reg;
    assign lane_out = lane_reg;

endmodule

`default_nettype wire

### src/disc_pair_overlap_penetration_top.sv
`default_nettype none

// Channel  Direction  Ports                      tdata fields (low bit up)
// s_       in         s_tvalid s_tready s_tdata  a_x a_y a_rad b_x b_y b_rad
// m_       out        m_tvalid m_tready m_tdata  overlapping depth push_x push_y
//
// One transaction per cycle unless the output stalls. The chain has three front
// stages (difference, squares, compare), one cell per root digit (16), depth and
// the two products (2), one cell per quotient bit (16), and the output register.
// Synchronous active-low reset empties every stage. A stalled output freezes
// the whole chain; s_tready follows the output side.
module disc_pair_overlap_penetration_top (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    // a_x, a_y, a_rad, b_x, b_y, b_rad, zero fill
    input  wire logic [dpo_pkg::IN_PAD-1:0]   s_tdata,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // overlapping, depth, push_x, push_y, zero fill
    output logic [dpo_pkg::OUT_PAD-1:0]       m_tdata
);
    import dpo_pkg::*;

    logic en;

    // Unpack the input transaction
    logic [CB-1:0] a_x, a_y, b_x, b_y;
    logic [CB-2:0] a_rad, b_rad;
    assign a_x   = s_tdata[CB-1:0];
    assign a_y   = s_tdata[2*CB-1:CB];
    assign a_rad = s_tdata[3*CB-2:2*CB];
    assign b_x   = s_tdata[4*CB-2:3*CB-1];
    assign b_y   = s_tdata[5*CB-2:4*CB-1];
    assign b_rad = s_tdata[6*CB-3:5*CB-1];

    // Front stage: differences, magnitudes, radius sum
    logic signed [CB:0] dx, dy;
    logic [CB:0]        mx, my;
    logic [CB-1:0]      rsum;
    assign dx   = $signed({b_x[CB-1], b_x}) - $signed({a_x[CB-1], a_x});
    assign dy   = $signed({b_y[CB-1], b_y}) - $signed({a_y[CB-1], a_y});
    assign mx   = dx[CB] ? -dx : dx;
    assign my   = dy[CB] ? -dy : dy;
    assign rsum = {1'b0, a_rad} + {1'b0, b_rad};

    logic          v0_reg;
    logic [CB-1:0] adx0_reg, ady0_reg, rsum0_reg;
    logic          sx0_reg, sy0_reg, near0_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            adx0_reg  <= mx[CB-1:0];
            ady0_reg  <= my[CB-1:0];
            rsum0_reg <= rsum;
            sx0_reg   <= dx[CB];
            sy0_reg   <= dy[CB];
            near0_reg <= (mx[CB-1:0] < rsum) && (my[CB-1:0] < rsum);
        end
    end

    // Square stage
    logic            v1_reg;
    logic [SQ_W-1:0] dx2_reg, dy2_reg, rsq_reg;
    logic [CB-1:0]   adx1_reg, ady1_reg, rsum1_reg;
    logic            sx1_reg, sy1_reg, near1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dx2_reg   <= adx0_reg * adx0_reg;
            dy2_reg   <= ady0_reg * ady0_reg;
            rsq_reg   <= rsum0_reg * rsum0_reg;
            adx1_reg  <= adx0_reg;
            ady1_reg  <= ady0_reg;
            rsum1_reg <= rsum0_reg;
            sx1_reg   <= sx0_reg;
            sy1_reg   <= sy0_reg;
            near1_reg <= near0_reg;
        end
    end

    // Compare stage feeds the root chain
    logic hit;
    assign hit = near1_reg && (dx2_reg < rsq_reg) && (dy2_reg < rsq_reg - dx2_reg);

    logic    sq_vld [0:CB];
    sq_pay_t sq_pay [0:CB];
    sq_st_t  sq_st  [0:CB];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_vld[0] <= 1'b0;
        end else if (en) begin
            sq_vld[0] <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_pay[0].hit  <= hit;
            sq_pay[0].rsum <= rsum1_reg;
            sq_pay[0].adx  <= adx1_reg;
            sq_pay[0].ady  <= ady1_reg;
            sq_pay[0].sx   <= sx1_reg;
            sq_pay[0].sy   <= sy1_reg;
            sq_st[0].n     <= hit ? dx2_reg + dy2_reg : '0;
            sq_st[0].root  <= '0;
        end
    end

    for (genvar g = 0; g < CB; g++) begin : g_sq
        dpo_sqrt_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .idx     (IDX_W'(g)),
            .vld_in  (sq_vld[g]),
            .pay_in  (sq_pay[g]),
            .st_in   (sq_st[g]),
            .vld_out (sq_vld[g+1]),
            .pay_out (sq_pay[g+1]),
            .st_out  (sq_st[g+1])
        );
    end

    // Depth stage
    logic          vd_reg;
    dv_pay_t       pd_reg;
    logic [CB-1:0] adxd_reg, adyd_reg;
    logic [CB-1:0] span;
    assign span = sq_st[CB].root[CB-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vd_reg <= 1'b0;
        end else if (en) begin
            vd_reg <= sq_vld[CB];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pd_reg.hit   <= sq_pay[CB].hit;
            pd_reg.depth <= sq_pay[CB].hit ? sq_pay[CB].rsum - span : '0;
            pd_reg.span  <= span;
            pd_reg.zd    <= !sq_pay[CB].hit || (span == '0);
            pd_reg.sx    <= sq_pay[CB].sx;
            pd_reg.sy    <= sq_pay[CB].sy;
            adxd_reg     <= sq_pay[CB].adx;
            adyd_reg     <= sq_pay[CB].ady;
        end
    end

    // Product stage feeds the divider chain
    logic     dv_vld  [0:CB];
    dv_pay_t  dv_pay  [0:CB];
    dv_lane_t dv_lane [0:CB];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_vld[0] <= 1'b0;
        end else if (en) begin
            dv_vld[0] <= vd_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dv_pay[0]     <= pd_reg;
            dv_lane[0].wx <= pd_reg.depth * adxd_reg;
            dv_lane[0].wy <= pd_reg.depth * adyd_reg;
        end
    end

    for (genvar g = 0; g < CB; g++) begin : g_dv
        dpo_div_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .vld_in   (dv_vld[g]),
            .pay_in   (dv_pay[g]),
            .lane_in  (dv_lane[g]),
            .vld_out  (dv_vld[g+1]),
            .pay_out  (dv_pay[g+1]),
            .lane_out (dv_lane[g+1])
        );
    end

    // Output register: apply signs, drop pushes for coincident or apart
    logic [CB:0] qx, qy, px, py;
    assign qx = {1'b0, dv_lane[CB].wx[CB-1:0]};
    assign qy = {1'b0, dv_lane[CB].wy[CB-1:0]};
    assign px = dv_pay[CB].zd ? '0 : (dv_pay[CB].sx ? -qx : qx);
    assign py = dv_pay[CB].zd ? '0 : (dv_pay[CB].sy ? -qy : qy);

    logic               m_tvalid_reg;
    logic [OUT_PAD-1:0] m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= dv_vld[CB];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= OUT_PAD'({py, px, dv_pay[CB].depth, dv_pay[CB].hit});
        end
    end

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Checks
    a_apart_no_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[CB:1] == '0)
        else $error("depth nonzero for discs apart");

    a_apart_no_push: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[OUT_W-1:CB+1] == '0)
        else $error("push nonzero for discs apart");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    a_ready_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

endmodule

`default_nettype wire
